@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define EPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define EPF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define EPF_ASSERT(label, clk, rst_n, prop, msg)

`define EPF_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

@@ hdl/epf_pkg.sv @@
// ----------------------------------------------------------------------------
// epf_pkg
// Shared types and constants of the escaped packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package epf_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 8;
    localparam int SEG_W  = 2;
    localparam int STAT_W = 2;

    // line bytes
    localparam logic [BYTE_W-1:0] SOF_BYTE = 8'd0;
    localparam logic [BYTE_W-1:0] EOF_BYTE = 8'd192;
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'd219;

    // frame status codes
    localparam logic [STAT_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABORT = 2'd2;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_HEADER  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_PAYLOAD = 2'd1;
    localparam logic [SEG_W-1:0] SEG_TAIL    = 2'd2;
    localparam logic [SEG_W-1:0] SEG_UNUSED  = 2'd3;

    // one classified request: what the emitter has to send for one input byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;   // data byte, already incremented when escaped
        logic              sof;    // start byte goes first
        logic              esc;    // escape byte before data
        logic              eof;    // end byte after data
        logic [STAT_W-1:0] status; // status of the final byte
    } epf_cmd_t;

endpackage

`default_nettype wire

@@ hdl/epf_classify.sv @@
// ----------------------------------------------------------------------------
// epf_classify
// Front end: tracks header/payload/tail position and turns each raw byte
// into an emit request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epf_classify
    import epf_pkg::*;
#(
    parameter int HEADER_BYTES = 4,
    parameter int PAYLOAD_MAX  = 64,
    parameter int TAIL_BYTES   = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [BYTE_W-1:0] in_byte,
    output      logic              in_ready,
    output      logic              push,
    output      epf_cmd_t          push_cmd,
    input  wire logic              q_ready
);

    localparam logic [POS_W-1:0]  HDR_LAST = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0]  TL_LAST  = POS_W'(TAIL_BYTES - 1);
    localparam logic [BYTE_W-1:0] LEN_MAX  = BYTE_W'(PAYLOAD_MAX);

    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic              accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign push     = accept;

    always_comb begin
        logic              special;
        logic [POS_W-1:0]  pos_eff;
        logic [BYTE_W-1:0] len_now;
        special = (in_byte == SOF_BYTE) || (in_byte == EOF_BYTE) || (in_byte == ESC_BYTE);
        pos_eff = pos_reg;
        len_now = len_reg;

        push_cmd.data   = special ? in_byte + 8'd1 : in_byte;
        push_cmd.esc    = special;
        push_cmd.sof    = 1'b0;
        push_cmd.eof    = 1'b0;
        push_cmd.status = ST_BUSY;
        seg_next        = seg_reg;
        pos_next        = pos_reg + 8'd1;
        len_next        = len_reg;

        unique case (seg_reg)
            SEG_PAYLOAD: begin
                if (pos_reg == len_reg - 8'd1) begin
                    pos_next = '0;
                    seg_next = SEG_TAIL;
                end
            end
            SEG_TAIL: begin
                if (pos_reg == TL_LAST) begin
                    push_cmd.eof    = 1'b1;
                    push_cmd.status = ST_DONE;
                    pos_next        = '0;
                    seg_next        = SEG_HEADER;
                end
            end
            default: begin
                // header; the unused code restarts a header
                if (seg_reg == SEG_UNUSED) begin
                    pos_eff = '0;
                end
                len_now      = (pos_eff == 8'd1) ? in_byte : len_reg;
                len_next     = len_now;
                push_cmd.sof = (pos_eff == '0);
                pos_next     = pos_eff + 8'd1;
                seg_next     = SEG_HEADER;
                if (pos_eff == HDR_LAST) begin
                    pos_next = '0;
                    if (len_now > LEN_MAX) begin
                        push_cmd.status = ST_ABORT;
                        seg_next        = SEG_HEADER;
                    end else if (len_now == '0) begin
                        seg_next = SEG_TAIL;
                    end else begin
                        seg_next = SEG_PAYLOAD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= SEG_HEADER;
            pos_reg <= '0;
            len_reg <= '0;
        end else if (accept) begin
            seg_reg <= seg_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    `EPF_ASSERT(a_abort_restarts, aclk, aresetn, push && push_cmd.status == ST_ABORT |=> seg_reg == SEG_HEADER && pos_reg == '0, "abort did not restart header")
    `EPF_ASSERT(a_sof_only_header, aclk, aresetn, push && push_cmd.sof |-> seg_reg != SEG_PAYLOAD && seg_reg != SEG_TAIL, "start byte outside header")
    `EPF_ASSERT_NEVER(a_no_sof_eof, aclk, aresetn, push && push_cmd.sof && push_cmd.eof, "start and end in one request")

endmodule

`default_nettype wire

@@ hdl/epf_queue.sv @@
// ----------------------------------------------------------------------------
// epf_queue
// Four-entry request queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epf_queue
    import epf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire epf_cmd_t push_cmd,
    output      logic     push_ready,
    input  wire logic     pop,
    output      epf_cmd_t head_cmd,
    output      logic     head_valid
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    epf_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `EPF_ASSERT_NEVER(a_q_overflow, aclk, aresetn, cnt_reg > CNT_W'(DEPTH), "queue count above depth")
    `EPF_ASSERT(a_q_ptr_gap, aclk, aresetn, cnt_reg == '0 || cnt_reg == CNT_W'(DEPTH) |-> wr_ptr_reg == rd_ptr_reg, "queue pointers out of step")

endmodule

`default_nettype wire

@@ hdl/epf_emit.sv @@
// ----------------------------------------------------------------------------
// epf_emit
// Back end: expands each request into start, escape, data and end bytes,
// one per cycle while out_ready does not hold the output, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epf_emit
    import epf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire epf_cmd_t          head_cmd,
    input  wire logic              head_valid,
    output      logic              pop,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [BYTE_W-1:0] out_byte,
    output      logic              out_last,
    output      logic [STAT_W-1:0] out_status
);

    epf_cmd_t          cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              dat_reg, dat_next;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [STAT_W-1:0] m_status_reg;

    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] piece_byte;
    logic              piece_last;
    epf_cmd_t          rem_cmd;
    logic              rem_dat;

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;

    // pick the next piece of the current request and what remains after it
    always_comb begin
        rem_cmd = cur_reg;
        rem_dat = dat_reg;
        if (cur_reg.sof) begin
            piece_byte  = SOF_BYTE;
            rem_cmd.sof = 1'b0;
        end else if (cur_reg.esc) begin
            piece_byte  = ESC_BYTE;
            rem_cmd.esc = 1'b0;
        end else if (dat_reg) begin
            piece_byte = cur_reg.data;
            rem_dat    = 1'b0;
        end else begin
            piece_byte  = EOF_BYTE;
            rem_cmd.eof = 1'b0;
        end
        piece_last = !rem_cmd.sof && !rem_cmd.esc && !rem_dat && !rem_cmd.eof;
    end

    always_comb begin
        pop            = 1'b0;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        dat_next       = dat_reg;
        if (!cur_valid_reg || (emit && piece_last)) begin
            pop            = head_valid;
            cur_next       = head_cmd;
            cur_valid_next = head_valid;
            dat_next       = 1'b1;
        end else if (emit) begin
            cur_next = rem_cmd;
            dat_next = rem_dat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        dat_reg <= dat_next;
        if (emit) begin
            m_byte_reg   <= piece_byte;
            m_last_reg   <= piece_last;
            m_status_reg <= piece_last ? cur_reg.status : ST_BUSY;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_byte   = m_byte_reg;
    assign out_last   = m_last_reg;
    assign out_status = m_status_reg;

    `EPF_ASSERT(a_done_is_eof, aclk, aresetn, m_valid_reg && m_status_reg == ST_DONE |-> m_byte_reg == EOF_BYTE && m_last_reg, "done status not on end byte")
    `EPF_ASSERT(a_esc_not_last, aclk, aresetn, m_valid_reg && m_byte_reg == ESC_BYTE |-> !m_last_reg, "escape byte closes a run")

endmodule

`default_nettype wire

@@ hdl/escaped_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// escaped_packet_framer_top
// Byte-stuffing packet framer: start byte, escaped header/payload/tail,
// end byte; oversize lengths abort the frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes raw packet bytes in s_tdata[7:0]: HEADER_BYTES header
//   bytes (byte 1 is the payload length), the payload, then TAIL_BYTES tail.
//   m_ channel gives line bytes in m_tdata[7:0], m_tlast on the final line
//   byte of each input byte, m_tuser[1:0] the frame status (1 on the end
//   byte, 2 on the last byte of an oversize header, else 0).
//   Each input byte gives 1 to 3 line bytes, sent one per cycle while m_tready
//   does not hold the output; the emitter's single output register sets that
//   rate. Input bytes are taken every cycle while the four-entry request queue
//   has room. The first line byte of an input byte passes through a queue
//   slot, the emitter's current-request register and the output register
//   when the queue and emitter are empty.
//   Reset (aresetn low, synchronous) empties the queue and output and starts
//   a new header. When m_tready is low the output holds, the queue fills and
//   s_tready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_packet_framer_top
    import epf_pkg::*;
#(
    parameter int HEADER_BYTES = 4,
    parameter int PAYLOAD_MAX  = 64,
    parameter int TAIL_BYTES   = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output      logic              m_tlast,
    output      logic [STAT_W-1:0] m_tuser    // [1:0] frame_status
);

    logic     push;
    epf_cmd_t push_cmd;
    logic     q_ready;
    logic     pop;
    epf_cmd_t head_cmd;
    logic     head_valid;

    epf_classify #(
        .HEADER_BYTES (HEADER_BYTES),
        .PAYLOAD_MAX  (PAYLOAD_MAX),
        .TAIL_BYTES   (TAIL_BYTES)
    ) u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    epf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    epf_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

endmodule

`default_nettype wire
